/* rtl/jps_pkg.sv */
// jump point search step: shared types, codes and command/status bundles
// no dependencies; used by every other file of the block but the two interfaces
`default_nettype none

package jps_pkg;

    // coordinates during a scan, wide enough for one step off a 127-cell grid
    typedef logic signed [8:0] t_coord;
    typedef logic signed [1:0] t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SPROBE,
        S_SWAIT,
        S_SEVAL,
        S_DPROBE,
        S_DWAIT,
        S_DEVAL,
        S_NPROBE,
        S_NWAIT,
        S_NBUILD,
        S_EMIT,
        S_RESULT
    } t_state;

    // which probe pattern the datapath applies
    typedef enum logic [1:0] {
        PK_SCAN,
        PK_DIAG,
        PK_NBR
    } t_probe;

    // straight scan start point
    typedef enum logic [1:0] {
        SI_NONE,
        SI_MAIN,
        SI_HORZ,
        SI_VERT
    } t_sinit;

    // role of the running straight scan
    typedef enum logic [1:0] {
        SUB_MAIN,
        SUB_HORZ,
        SUB_VERT
    } t_sub;

    // result source for the output register
    typedef enum logic [1:0] {
        RS_NONE,
        RS_SCAN,
        RS_DIAG,
        RS_LIST
    } t_rsel;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_JUMP  = 2'd1;
    localparam logic [1:0] MODE_NBR   = 2'd2;
    localparam logic [1:0] MODE_SKIP  = 2'd3;

    localparam logic [1:0] REG_GOAL_X = 2'd0;
    localparam logic [1:0] REG_GOAL_Y = 2'd1;
    localparam logic [1:0] REG_GRID_W = 2'd2;
    localparam logic [1:0] REG_GRID_H = 2'd3;

    localparam logic [2:0] SCAN_LAST = 3'd4;
    localparam logic [2:0] DIAG_LAST = 3'd6;
    localparam logic [2:0] NBR_LAST  = 3'd3;
    localparam int         MAX_NBR   = 5;

    typedef struct packed {
        logic [5:0] goal_x;
        logic [5:0] goal_y;
        logic [6:0] grid_w;
        logic [6:0] grid_h;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       wr;
        logic       probe_en;
        t_probe     probe_kind;
        logic [2:0] probe_idx;
        t_sinit     scan_init;
        logic       scan_step;
        logic       diag_step;
        logic       build;
        logic       out_load;
        t_rsel      res_sel;
        logic [2:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       dir_zero;
        logic       dir_diag;
        logic       open0;
        logic       s_goal;
        logic       corner;
        logic       s_zero;
        logic       d_goal;
        logic       d_step;
        logic [2:0] lcnt;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

/* rtl/jps_in_if.sv */
// request channel into the jump point search step
// no dependencies
`default_nettype none

interface jps_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [5:0]        cell_x;
    logic [5:0]        cell_y;
    logic signed [1:0] dir_x;
    logic signed [1:0] dir_y;
    logic              walkable;

    modport source (output valid, mode, cell_x, cell_y, dir_x, dir_y, walkable,
                    input ready);
    modport sink   (input valid, mode, cell_x, cell_y, dir_x, dir_y, walkable,
                    output ready);
endinterface

`default_nettype wire

/* rtl/jps_out_if.sv */
// result channel out of the jump point search step
// no dependencies
`default_nettype none

interface jps_out_if;
    logic              valid;
    logic              ready;
    logic              found;
    logic signed [7:0] point_x;
    logic signed [7:0] point_y;
    logic              last;

    modport source (output valid, found, point_x, point_y, last, input ready);
    modport sink   (input valid, found, point_x, point_y, last, output ready);
endinterface

`default_nettype wire

/* rtl/jump_point_search_step.sv */
// jump point search step over a walkability bit map
// depends on jps_pkg, jps_in_if, jps_out_if, jps_ctrl, jps_datapath
//
// Requests arrive on i_in (valid/ready). Mode 0 writes one map cell and
// gives no result; mode 1 runs one jump and gives one result; mode 2 gives
// up to five pruned neighbors, the final one marked by last. Mode 3 is
// dropped. Results leave through o_out from an output register, so a
// stalled receiver only holds the block when the next result is ready.
// The APB port sets goal_x, goal_y, grid_width and grid_height; write it
// only while no request is in flight.
// A write is latched from the request and then stored in the map. Every map
// probe is one read of the single map port; a straight jump probes each cell
// it scans, a diagonal jump each diagonal cell plus both straight sub-scans.
// A neighbor query probes its cells, builds the list and gives the neighbors
// in order; with none it gives one not-found result instead.
// One request is worked at a time; the next is taken once the current one
// has placed its last result in the output register.
// Reset sets the registers to goal 0,0 and a 64 x 64 grid and empties the
// output register; map contents are undefined until written.
`default_nettype none

module jump_point_search_step #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jps_in_if.sink      i_in,
    jps_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] r_goal_x, r_goal_y;
    logic [6:0] r_grid_w, r_grid_h;
    logic [1:0] reg_idx;
    jps_pkg::t_cfg    cfg;
    jps_pkg::t_cmd    cmd;
    jps_pkg::t_status status;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= 6'd0;
            r_goal_y <= 6'd0;
            r_grid_w <= 7'd64;
            r_grid_h <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                jps_pkg::REG_GOAL_X: r_goal_x <= pwdata[5:0];
                jps_pkg::REG_GOAL_Y: r_goal_y <= pwdata[5:0];
                jps_pkg::REG_GRID_W: r_grid_w <= pwdata[6:0];
                default:             r_grid_h <= pwdata[6:0];
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            jps_pkg::REG_GOAL_X: prdata = {26'd0, r_goal_x};
            jps_pkg::REG_GOAL_Y: prdata = {26'd0, r_goal_y};
            jps_pkg::REG_GRID_W: prdata = {25'd0, r_grid_w};
            default:             prdata = {25'd0, r_grid_h};
        endcase
    end

    assign cfg = '{goal_x: r_goal_x, goal_y: r_goal_y, grid_w: r_grid_w, grid_h: r_grid_h};

    jps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_mode      (i_in.mode),
        .i_cell_x    (i_in.cell_x),
        .i_cell_y    (i_in.cell_y),
        .i_dir_x     (i_in.dir_x),
        .i_dir_y     (i_in.dir_y),
        .i_walkable  (i_in.walkable),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_found     (o_out.found),
        .o_point_x   (o_out.point_x),
        .o_point_y   (o_out.point_y),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire

/* rtl/jps_datapath.sv */
// datapath: map memory, probe address unit, scan positions, flags,
// neighbor list and output register; depends on jps_pkg
`default_nettype none

module jps_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jps_pkg::t_cfg      i_cfg,
    input  jps_pkg::t_cmd      i_cmd,
    output jps_pkg::t_status   o_status,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic signed [1:0]  i_dir_x,
    input  logic signed [1:0]  i_dir_y,
    input  logic               i_walkable,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_found,
    output logic signed [7:0]  o_point_x,
    output logic signed [7:0]  o_point_y,
    output logic               o_last
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    function automatic jps_pkg::t_dir dir_of(logic [1:0] v);
        unique case (v)
            2'b00:   return 2'sb00;
            2'b01:   return 2'sb01;
            default: return 2'sb11;
        endcase
    endfunction

    function automatic jps_pkg::t_coord ext(jps_pkg::t_dir d);
        return {{7{d[1]}}, d};
    endfunction

    // latched request and scan state
    logic [1:0]       r_mode;
    logic             r_walk;
    jps_pkg::t_coord  r_x, r_y, r_sx, r_sy;
    jps_pkg::t_dir    r_dx, r_dy, r_sdx, r_sdy;
    logic [6:0]       r_f;
    logic             r_rd, r_inb, r_cap_en;
    logic [2:0]       r_cap_idx;
    jps_pkg::t_coord  r_lx [jps_pkg::MAX_NBR];
    jps_pkg::t_coord  r_ly [jps_pkg::MAX_NBR];
    logic [2:0]       r_lcnt;
    logic             r_ovalid, r_found, r_last;
    logic signed [7:0] r_px, r_py;
    logic             r_mem [DEPTH];

    jps_pkg::t_coord  base_x, base_y, pr_x, pr_y;
    jps_pkg::t_dir    ox, oy, pq_x, pq_y;
    logic [6:0]       w_eff, h_eff;
    logic             inb, wr_en, out_free;
    logic [AW-1:0]    raddr, waddr;

    // perpendicular unit of the straight scan
    assign pq_x = (r_sdy != 2'sb00) ? 2'sb01 : 2'sb00;
    assign pq_y = (r_sdx != 2'sb00) ? 2'sb01 : 2'sb00;

    // probe offset pattern
    always_comb begin
        base_x = r_x;
        base_y = r_y;
        ox     = 2'sb00;
        oy     = 2'sb00;
        unique case (i_cmd.probe_kind)
            jps_pkg::PK_SCAN: begin
                base_x = r_sx;
                base_y = r_sy;
                unique case (i_cmd.probe_idx)
                    3'd1:    begin ox = r_sdx + pq_x; oy = r_sdy + pq_y; end
                    3'd2:    begin ox = pq_x;         oy = pq_y;         end
                    3'd3:    begin ox = r_sdx - pq_x; oy = r_sdy - pq_y; end
                    3'd4:    begin ox = -pq_x;        oy = -pq_y;        end
                    default: ;
                endcase
            end
            jps_pkg::PK_DIAG: begin
                unique case (i_cmd.probe_idx)
                    3'd1:    begin ox = -r_dx; oy = r_dy;  end
                    3'd2:    begin ox = -r_dx;             end
                    3'd3:    begin ox = r_dx;  oy = -r_dy; end
                    3'd4:    begin             oy = -r_dy; end
                    3'd5:    begin ox = r_dx;              end
                    3'd6:    begin             oy = r_dy;  end
                    default: ;
                endcase
            end
            jps_pkg::PK_NBR: begin
                priority if (r_dx != 2'sb00 && r_dy != 2'sb00) begin
                    unique case (i_cmd.probe_idx)
                        3'd0:    oy = r_dy;
                        3'd1:    ox = r_dx;
                        3'd2:    ox = -r_dx;
                        3'd3:    oy = -r_dy;
                        default: ;
                    endcase
                end else if (r_dx == 2'sb00) begin
                    unique case (i_cmd.probe_idx)
                        3'd0:    oy = r_dy;
                        3'd1:    ox = 2'sb01;
                        3'd2:    ox = 2'sb11;
                        default: ;
                    endcase
                end else begin
                    unique case (i_cmd.probe_idx)
                        3'd0:    ox = r_dx;
                        3'd1:    oy = 2'sb01;
                        3'd2:    oy = 2'sb11;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // probe position and bounds against the used grid
    assign pr_x  = base_x + ext(ox);
    assign pr_y  = base_y + ext(oy);
    assign w_eff = (32'(i_cfg.grid_w) < MAX_WIDTH)  ? i_cfg.grid_w : 7'(MAX_WIDTH);
    assign h_eff = (32'(i_cfg.grid_h) < MAX_HEIGHT) ? i_cfg.grid_h : 7'(MAX_HEIGHT);
    assign inb   = (pr_x >= 0) && (pr_y >= 0)
                && (pr_x < $signed({2'b00, w_eff})) && (pr_y < $signed({2'b00, h_eff}));
    assign raddr = AW'(AW'(pr_y[7:0]) * AW'(MAX_WIDTH) + AW'(pr_x[7:0]));
    assign waddr = AW'(AW'(r_y[7:0]) * AW'(MAX_WIDTH) + AW'(r_x[7:0]));
    assign wr_en = i_cmd.wr && (32'(r_x[7:0]) < MAX_WIDTH) && (32'(r_y[7:0]) < MAX_HEIGHT);

    // map memory, one port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= r_walk;
        end
        r_rd  <= r_mem[raddr];
        r_inb <= inb;
    end

    // probe result capture in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.probe_en;
        end
        r_cap_idx <= i_cmd.probe_idx;
        if (r_cap_en) begin
            r_f[r_cap_idx] <= r_inb & r_rd;
        end
    end

    // request latch and scan positions
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_walk <= i_walkable;
            r_x    <= jps_pkg::t_coord'({3'b000, i_cell_x});
            r_y    <= jps_pkg::t_coord'({3'b000, i_cell_y});
            r_dx   <= dir_of(i_dir_x);
            r_dy   <= dir_of(i_dir_y);
        end else if (i_cmd.diag_step) begin
            r_x <= r_x + ext(r_dx);
            r_y <= r_y + ext(r_dy);
        end
        unique case (i_cmd.scan_init)
            jps_pkg::SI_MAIN: begin
                r_sx <= r_x;  r_sy <= r_y;  r_sdx <= r_dx;   r_sdy <= r_dy;
            end
            jps_pkg::SI_HORZ: begin
                r_sx <= r_x + ext(r_dx); r_sy <= r_y; r_sdx <= r_dx; r_sdy <= 2'sb00;
            end
            jps_pkg::SI_VERT: begin
                r_sx <= r_x; r_sy <= r_y + ext(r_dy); r_sdx <= 2'sb00; r_sdy <= r_dy;
            end
            default: begin
                if (i_cmd.scan_step) begin
                    r_sx <= r_sx + ext(r_sdx);
                    r_sy <= r_sy + ext(r_sdy);
                end
            end
        endcase
    end

    // pruned neighbor candidates and compaction
    jps_pkg::t_coord cx [jps_pkg::MAX_NBR];
    jps_pkg::t_coord cy [jps_pkg::MAX_NBR];
    logic [jps_pkg::MAX_NBR-1:0] cv;
    jps_pkg::t_coord nx [jps_pkg::MAX_NBR];
    jps_pkg::t_coord ny [jps_pkg::MAX_NBR];
    logic [2:0] ncnt;

    always_comb begin
        for (int k = 0; k < jps_pkg::MAX_NBR; k++) begin
            cx[k] = r_x;
            cy[k] = r_y;
        end
        cv = '0;
        priority if (r_dx != 2'sb00 && r_dy != 2'sb00) begin
            cy[0] = r_y + ext(r_dy);                              cv[0] = r_f[0];
            cx[1] = r_x + ext(r_dx);                              cv[1] = r_f[1];
            cx[2] = r_x + ext(r_dx); cy[2] = r_y + ext(r_dy);     cv[2] = r_f[0] | r_f[1];
            cx[3] = r_x - ext(r_dx); cy[3] = r_y + ext(r_dy);     cv[3] = !r_f[2] & r_f[0];
            cx[4] = r_x + ext(r_dx); cy[4] = r_y - ext(r_dy);     cv[4] = !r_f[3] & r_f[1];
        end else if (r_dx == 2'sb00 && r_dy != 2'sb00) begin
            cy[0] = r_y + ext(r_dy);                              cv[0] = r_f[0];
            cx[1] = r_x + 9'sd1;     cy[1] = r_y + ext(r_dy);     cv[1] = r_f[0] & !r_f[1];
            cx[2] = r_x - 9'sd1;     cy[2] = r_y + ext(r_dy);     cv[2] = r_f[0] & !r_f[2];
        end else if (r_dx != 2'sb00) begin
            cx[0] = r_x + ext(r_dx);                              cv[0] = r_f[0];
            cx[1] = r_x + ext(r_dx); cy[1] = r_y + 9'sd1;         cv[1] = r_f[0] & !r_f[1];
            cx[2] = r_x + ext(r_dx); cy[2] = r_y - 9'sd1;         cv[2] = r_f[0] & !r_f[2];
        end else begin
            cv = '0;
        end
    end

    always_comb begin
        ncnt = 3'd0;
        for (int k = 0; k < jps_pkg::MAX_NBR; k++) begin
            nx[k] = cx[k];
            ny[k] = cy[k];
        end
        for (int k = 0; k < jps_pkg::MAX_NBR; k++) begin
            if (cv[k]) begin
                nx[ncnt] = cx[k];
                ny[ncnt] = cy[k];
                ncnt     = ncnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build) begin
            r_lx   <= nx;
            r_ly   <= ny;
            r_lcnt <= ncnt;
        end
    end

    // output register
    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.res_sel)
                jps_pkg::RS_SCAN: begin
                    r_found <= 1'b1; r_px <= r_sx[7:0]; r_py <= r_sy[7:0]; r_last <= 1'b1;
                end
                jps_pkg::RS_DIAG: begin
                    r_found <= 1'b1; r_px <= r_x[7:0]; r_py <= r_y[7:0]; r_last <= 1'b1;
                end
                jps_pkg::RS_LIST: begin
                    r_found <= 1'b1;
                    r_px    <= r_lx[i_cmd.emit_idx][7:0];
                    r_py    <= r_ly[i_cmd.emit_idx][7:0];
                    r_last  <= (i_cmd.emit_idx == r_lcnt - 3'd1);
                end
                default: begin
                    r_found <= 1'b0; r_px <= 8'sd0; r_py <= 8'sd0; r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_found     = r_found;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_last      = r_last;

    // status toward the controller
    always_comb begin
        o_status.mode     = r_mode;
        o_status.dir_zero = (r_dx == 2'sb00) && (r_dy == 2'sb00);
        o_status.dir_diag = (r_dx != 2'sb00) && (r_dy != 2'sb00);
        o_status.open0    = r_f[0];
        o_status.s_goal   = (r_sx >= 0) && (r_sy >= 0)
                         && (r_sx == $signed({3'b000, i_cfg.goal_x}))
                         && (r_sy == $signed({3'b000, i_cfg.goal_y}));
        o_status.corner   = (r_f[1] & !r_f[2]) | (r_f[3] & !r_f[4]);
        o_status.s_zero   = (r_sdx == 2'sb00) && (r_sdy == 2'sb00);
        o_status.d_goal   = (r_x >= 0) && (r_y >= 0)
                         && (r_x == $signed({3'b000, i_cfg.goal_x}))
                         && (r_y == $signed({3'b000, i_cfg.goal_y}));
        o_status.d_step   = r_f[5] | r_f[6];
        o_status.lcnt     = r_lcnt;
        o_status.out_free = out_free;
    end

endmodule

`default_nettype wire

/* rtl/jps_ctrl.sv */
// controller: sequences map probes, scan evaluation and result emission
// depends on jps_pkg
`default_nettype none

module jps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  jps_pkg::t_status i_status,
    output jps_pkg::t_cmd    o_cmd
);

    jps_pkg::t_state r_state, n_state;
    logic [2:0]      r_cnt, n_cnt, r_emit, n_emit;
    jps_pkg::t_sub   r_sub, n_sub;
    jps_pkg::t_rsel  r_rsel, n_rsel;

    logic s_fail, s_hit;

    // straight scan verdict at the current cell
    assign s_fail = !i_status.open0 || (!i_status.s_goal && i_status.s_zero);
    assign s_hit  = i_status.s_goal || i_status.corner;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        n_rsel  = r_rsel;
        n_emit  = r_emit;
        unique case (r_state)
            jps_pkg::S_IDLE: begin
                if (i_in_valid) n_state = jps_pkg::S_DISPATCH;
            end
            jps_pkg::S_DISPATCH: begin
                n_cnt = 3'd0;
                priority if (i_status.mode == jps_pkg::MODE_WRITE) begin
                    n_state = jps_pkg::S_IDLE;
                end else if (i_status.mode == jps_pkg::MODE_JUMP) begin
                    n_sub   = jps_pkg::SUB_MAIN;
                    n_state = i_status.dir_diag ? jps_pkg::S_DPROBE : jps_pkg::S_SPROBE;
                end else if (i_status.mode == jps_pkg::MODE_NBR) begin
                    n_rsel  = jps_pkg::RS_NONE;
                    n_state = i_status.dir_zero ? jps_pkg::S_RESULT : jps_pkg::S_NPROBE;
                end else begin
                    n_state = jps_pkg::S_IDLE;
                end
            end
            jps_pkg::S_SPROBE: begin
                if (r_cnt == jps_pkg::SCAN_LAST) begin
                    n_cnt   = 3'd0;
                    n_state = jps_pkg::S_SWAIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            jps_pkg::S_SWAIT: n_state = jps_pkg::S_SEVAL;
            jps_pkg::S_SEVAL: begin
                priority if (s_fail) begin
                    unique case (r_sub)
                        jps_pkg::SUB_HORZ: begin
                            n_sub   = jps_pkg::SUB_VERT;
                            n_state = jps_pkg::S_SPROBE;
                        end
                        jps_pkg::SUB_VERT: begin
                            if (i_status.d_step) begin
                                n_state = jps_pkg::S_DPROBE;
                            end else begin
                                n_rsel  = jps_pkg::RS_NONE;
                                n_state = jps_pkg::S_RESULT;
                            end
                        end
                        default: begin
                            n_rsel  = jps_pkg::RS_NONE;
                            n_state = jps_pkg::S_RESULT;
                        end
                    endcase
                end else if (s_hit) begin
                    n_rsel  = (r_sub == jps_pkg::SUB_MAIN) ? jps_pkg::RS_SCAN
                                                           : jps_pkg::RS_DIAG;
                    n_state = jps_pkg::S_RESULT;
                end else begin
                    n_state = jps_pkg::S_SPROBE;
                end
            end
            jps_pkg::S_DPROBE: begin
                if (r_cnt == jps_pkg::DIAG_LAST) begin
                    n_cnt   = 3'd0;
                    n_state = jps_pkg::S_DWAIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            jps_pkg::S_DWAIT: n_state = jps_pkg::S_DEVAL;
            jps_pkg::S_DEVAL: begin
                priority if (!i_status.open0) begin
                    n_rsel  = jps_pkg::RS_NONE;
                    n_state = jps_pkg::S_RESULT;
                end else if (i_status.d_goal || i_status.corner) begin
                    n_rsel  = jps_pkg::RS_DIAG;
                    n_state = jps_pkg::S_RESULT;
                end else begin
                    n_sub   = jps_pkg::SUB_HORZ;
                    n_state = jps_pkg::S_SPROBE;
                end
            end
            jps_pkg::S_NPROBE: begin
                if (r_cnt == jps_pkg::NBR_LAST) begin
                    n_cnt   = 3'd0;
                    n_state = jps_pkg::S_NWAIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            jps_pkg::S_NWAIT: n_state = jps_pkg::S_NBUILD;
            jps_pkg::S_NBUILD: begin
                n_emit  = 3'd0;
                n_state = jps_pkg::S_EMIT;
            end
            jps_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    if (i_status.lcnt == 3'd0 || r_emit == i_status.lcnt - 3'd1) begin
                        n_state = jps_pkg::S_IDLE;
                    end else begin
                        n_emit = r_emit + 3'd1;
                    end
                end
            end
            jps_pkg::S_RESULT: begin
                if (i_status.out_free) n_state = jps_pkg::S_IDLE;
            end
            default: n_state = jps_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.probe_kind = jps_pkg::PK_SCAN;
        o_cmd.scan_init  = jps_pkg::SI_NONE;
        o_cmd.res_sel    = jps_pkg::RS_NONE;
        o_cmd.probe_idx  = r_cnt;
        o_cmd.emit_idx   = r_emit;
        o_in_ready       = (r_state == jps_pkg::S_IDLE);
        unique case (r_state)
            jps_pkg::S_IDLE: o_cmd.load = i_in_valid;
            jps_pkg::S_DISPATCH: begin
                o_cmd.wr = (i_status.mode == jps_pkg::MODE_WRITE);
                if (i_status.mode == jps_pkg::MODE_JUMP && !i_status.dir_diag) begin
                    o_cmd.scan_init = jps_pkg::SI_MAIN;
                end
            end
            jps_pkg::S_SPROBE: o_cmd.probe_en = 1'b1;
            jps_pkg::S_DPROBE: begin
                o_cmd.probe_en   = 1'b1;
                o_cmd.probe_kind = jps_pkg::PK_DIAG;
            end
            jps_pkg::S_NPROBE: begin
                o_cmd.probe_en   = 1'b1;
                o_cmd.probe_kind = jps_pkg::PK_NBR;
            end
            jps_pkg::S_SEVAL: begin
                priority if (s_fail) begin
                    if (r_sub == jps_pkg::SUB_HORZ) begin
                        o_cmd.scan_init = jps_pkg::SI_VERT;
                    end else if (r_sub == jps_pkg::SUB_VERT && i_status.d_step) begin
                        o_cmd.diag_step = 1'b1;
                    end
                end else if (s_hit) begin
                    o_cmd.scan_step = 1'b0;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            jps_pkg::S_DEVAL: begin
                if (i_status.open0 && !i_status.d_goal && !i_status.corner) begin
                    o_cmd.scan_init = jps_pkg::SI_HORZ;
                end
            end
            jps_pkg::S_NBUILD: o_cmd.build = 1'b1;
            jps_pkg::S_EMIT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.res_sel  = (i_status.lcnt == 3'd0) ? jps_pkg::RS_NONE
                                                         : jps_pkg::RS_LIST;
            end
            jps_pkg::S_RESULT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.res_sel  = r_rsel;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jps_pkg::S_IDLE;
            r_cnt   <= 3'd0;
            r_emit  <= 3'd0;
            r_sub   <= jps_pkg::SUB_MAIN;
            r_rsel  <= jps_pkg::RS_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
            r_sub   <= n_sub;
            r_rsel  <= n_rsel;
        end
    end

    // checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded into a busy output register");

    a_no_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_step |-> !i_status.s_zero)
        else $error("straight scan stepped with zero direction");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jps_pkg::S_EMIT && i_status.lcnt != 3'd0)
            |-> (r_emit < i_status.lcnt))
        else $error("neighbor emit index past list end");

    a_probe_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jps_pkg::S_SEVAL || r_state == jps_pkg::S_DEVAL)
            |-> $past(r_state == jps_pkg::S_SWAIT || r_state == jps_pkg::S_DWAIT))
        else $error("evaluation without the wait for the last probe");

endmodule

`default_nettype wire

/* verif/tb_jump_point_search_step.sv */
// testbench for jump_point_search_step: directed and random map writes, jumps and
// neighbor queries checked against an in-bench predictor of the search
// depends on jps_pkg, jps_in_if, jps_out_if and the rtl top level
`default_nettype none

module tb_jump_point_search_step;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]        mode;
        logic [5:0]        cell_x;
        logic [5:0]        cell_y;
        logic signed [1:0] dir_x;
        logic signed [1:0] dir_y;
        logic              walkable;
    } t_request;

    typedef struct {
        logic              found;
        logic signed [7:0] point_x;
        logic signed [7:0] point_y;
        logic              last;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    jps_in_if  req_ch ();
    jps_out_if res_ch ();

    jump_point_search_step u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .o_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    bit   walk_map [GW*GH];
    int   goal_col = 0, goal_row = 0, used_w = 64, used_h = 64;
    t_request pending_reqs[$];
    t_point   expected_pts[$];
    int   errors = 0;
    int   cycles = 0;

    function automatic bit is_open(int x, int y);
        int w, h;
        w = used_w < GW ? used_w : GW;
        h = used_h < GH ? used_h : GH;
        if (x < 0 || y < 0 || x >= w || y >= h) return 0;
        return walk_map[y*GW + x];
    endfunction

    function automatic bit at_goal(int x, int y);
        return x == goal_col && y == goal_row;
    endfunction

    function automatic bit run_straight(int x, int y, int dx, int dy,
                                        output int fx, output int fy);
        bit forced;
        forever begin
            if (!is_open(x, y)) return 0;
            if (at_goal(x, y)) break;
            if (dx != 0)
                forced = (is_open(x+dx, y+1) && !is_open(x, y+1)) ||
                         (is_open(x+dx, y-1) && !is_open(x, y-1));
            else
                forced = (is_open(x+1, y+dy) && !is_open(x+1, y)) ||
                         (is_open(x-1, y+dy) && !is_open(x-1, y));
            if (forced) break;
            x += dx;
            y += dy;
        end
        fx = x;
        fy = y;
        return 1;
    endfunction

    function automatic bit run_diagonal(int x, int y, int dx, int dy,
                                        output int fx, output int fy);
        int sx, sy;
        forever begin
            if (!is_open(x, y)) return 0;
            if (at_goal(x, y)) break;
            if ((is_open(x-dx, y+dy) && !is_open(x-dx, y)) ||
                (is_open(x+dx, y-dy) && !is_open(x, y-dy))) break;
            if (run_straight(x+dx, y, dx, 0, sx, sy) ||
                run_straight(x, y+dy, 0, dy, sx, sy)) break;
            if (!(is_open(x+dx, y) || is_open(x, y+dy))) return 0;
            x += dx;
            y += dy;
        end
        fx = x;
        fy = y;
        return 1;
    endfunction

    function automatic void push_point(bit f, int x, int y, bit l);
        t_point p;
        p.found = f;
        p.point_x = x[7:0];
        p.point_y = y[7:0];
        p.last = l;
        expected_pts = {expected_pts, p};
    endfunction

    // work out the results of one accepted request
    function automatic void predict_request(t_request r);
        int x, y, dx, dy, fx, fy, n;
        int px[5], py[5];
        bit ok, oy, ox;
        x = int'(r.cell_x);
        y = int'(r.cell_y);
        dx = r.dir_x == 0 ? 0 : (r.dir_x == 1 ? 1 : -1);
        dy = r.dir_y == 0 ? 0 : (r.dir_y == 1 ? 1 : -1);
        n = 0;
        fx = 0;
        fy = 0;
        case (r.mode)
            jps_pkg::MODE_WRITE: begin
                walk_map[y*GW + x] = r.walkable;
            end
            jps_pkg::MODE_JUMP: begin
                if (dx == 0 && dy == 0) begin
                    ok = is_open(x, y) && at_goal(x, y);
                    fx = x;
                    fy = y;
                end else if (dx != 0 && dy != 0) begin
                    ok = run_diagonal(x, y, dx, dy, fx, fy);
                end else begin
                    ok = run_straight(x, y, dx, dy, fx, fy);
                end
                if (ok) push_point(1, fx, fy, 1);
                else push_point(0, 0, 0, 1);
            end
            jps_pkg::MODE_NBR: begin
                if (dx != 0 && dy != 0) begin
                    oy = is_open(x, y+dy);
                    ox = is_open(x+dx, y);
                    if (oy) begin px[n] = x; py[n] = y+dy; n++; end
                    if (ox) begin px[n] = x+dx; py[n] = y; n++; end
                    if (oy || ox) begin px[n] = x+dx; py[n] = y+dy; n++; end
                    if (!is_open(x-dx, y) && oy) begin px[n] = x-dx; py[n] = y+dy; n++; end
                    if (!is_open(x, y-dy) && ox) begin px[n] = x+dx; py[n] = y-dy; n++; end
                end else if (dy != 0) begin
                    if (is_open(x, y+dy)) begin
                        px[n] = x; py[n] = y+dy; n++;
                        if (!is_open(x+1, y)) begin px[n] = x+1; py[n] = y+dy; n++; end
                        if (!is_open(x-1, y)) begin px[n] = x-1; py[n] = y+dy; n++; end
                    end
                end else if (dx != 0) begin
                    if (is_open(x+dx, y)) begin
                        px[n] = x+dx; py[n] = y; n++;
                        if (!is_open(x, y+1)) begin px[n] = x+dx; py[n] = y+1; n++; end
                        if (!is_open(x, y-1)) begin px[n] = x+dx; py[n] = y-1; n++; end
                    end
                end
                if (n == 0) push_point(0, 0, 0, 1);
                for (int k = 0; k < n; k++) push_point(1, px[k], py[k], k == n-1);
            end
            default: ;
        endcase
    endfunction

    // request driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    initial begin
        req_ch.valid = 0; req_ch.mode = jps_pkg::MODE_WRITE;
        req_ch.cell_x = 0; req_ch.cell_y = 0;
        req_ch.dir_x = 0; req_ch.dir_y = 0; req_ch.walkable = 0;
    end
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                pending_reqs.pop_front();
                burst_left = burst_left - 1;
            end else if (!req_ch.valid && gap_left > 0) begin
                gap_left = gap_left - 1;
            end
            if (burst_left <= 0 && gap_left == 0 && !(req_ch.valid && !req_ch.ready)) begin
                burst_left = $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
            if (pending_reqs.size() > 0 && (gap_left == 0 || burst_left > 0)
                && !(gap_left > 0 && !req_ch.valid)) begin
                req_ch.valid <= 1;
                req_ch.mode <= pending_reqs[0].mode;
                req_ch.cell_x <= pending_reqs[0].cell_x;
                req_ch.cell_y <= pending_reqs[0].cell_y;
                req_ch.dir_x <= pending_reqs[0].dir_x;
                req_ch.dir_y <= pending_reqs[0].dir_y;
                req_ch.walkable <= pending_reqs[0].walkable;
            end else begin
                req_ch.valid <= 0;
            end
        end
    end

    // receiver stall pattern
    logic [7:0] stall_pat = 8'b0;
    int stall_phase = 0;
    initial res_ch.ready = 0;
    always @(negedge i_clk) begin
        stall_phase = stall_phase + 1;
        if (stall_phase % 40 == 0)
            stall_pat = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
        res_ch.ready <= ~stall_pat[stall_phase % 8];
    end

    // monitor: predict on request accept, compare on result accept
    always @(posedge i_clk) begin
        t_point exp_pt;
        cycles <= cycles + 1;
        if (i_rst_n && req_ch.valid && req_ch.ready) predict_request(pending_reqs[0]);
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_pts.size() == 0) begin
                $display("%0t: unexpected result found=%b x=%0d y=%0d last=%b", $time,
                         res_ch.found, res_ch.point_x, res_ch.point_y, res_ch.last);
                errors <= errors + 1;
            end else begin
                exp_pt = expected_pts.pop_front();
                if (exp_pt.found !== res_ch.found || exp_pt.point_x !== res_ch.point_x ||
                    exp_pt.point_y !== res_ch.point_y || exp_pt.last !== res_ch.last) begin
                    $display("%0t: mismatch expected found=%b x=%0d y=%0d last=%b",
                             $time, exp_pt.found, exp_pt.point_x, exp_pt.point_y,
                             exp_pt.last, ", actual found=%b x=%0d y=%0d last=%b",
                             res_ch.found, res_ch.point_x, res_ch.point_y, res_ch.last);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input int value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (reg_idx)
            jps_pkg::REG_GOAL_X: goal_col = value & 63;
            jps_pkg::REG_GOAL_Y: goal_row = value & 63;
            jps_pkg::REG_GRID_W: used_w = value & 127;
            default:             used_h = value & 127;
        endcase
    endtask

    task automatic queue_request(input logic [1:0] m, input int x, input int y,
                                 input logic signed [1:0] dx, input logic signed [1:0] dy,
                                 input bit w);
        t_request r;
        r.mode = m; r.cell_x = 6'(x); r.cell_y = 6'(y);
        r.dir_x = dx; r.dir_y = dy; r.walkable = w;
        pending_reqs = {pending_reqs, r};
    endtask

    // wait until the block has drained every queued request
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_pts.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // random query whose probes stay within written cells of the region
    task automatic random_query(input int rw, input int rh);
        int x, y;
        x = $urandom_range(0, rw-1);
        y = $urandom_range(0, rh-1);
        queue_request(2'($urandom_range(1, 2)), x, y, 2'($urandom), 2'($urandom),
                      1'($urandom));
    endtask

    // fill the used region with a random map, sparse obstacles
    task automatic fill_map(input int rw, input int rh, input int blocked_pct);
        for (int y = 0; y < rh; y++)
            for (int x = 0; x < rw; x++)
                queue_request(jps_pkg::MODE_WRITE, x, y, 0, 0,
                              $urandom_range(0, 99) >= blocked_pct);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: small grid written open, goal inside, every mode with straight, diagonal and zero directions
        apb_write(jps_pkg::REG_GRID_W, 6);
        apb_write(jps_pkg::REG_GRID_H, 6);
        apb_write(jps_pkg::REG_GOAL_X, 4);
        apb_write(jps_pkg::REG_GOAL_Y, 4);
        fill_map(6, 6, 0);
        queue_request(jps_pkg::MODE_WRITE, 2, 2, 0, 0, 0);
        queue_request(jps_pkg::MODE_WRITE, 5, 1, 0, 0, 0);
        queue_request(jps_pkg::MODE_WRITE, 63, 63, 0, 0, 1);
        queue_request(jps_pkg::MODE_JUMP, 0, 0, 1, 1, 0);
        queue_request(jps_pkg::MODE_JUMP, 0, 4, 1, 0, 0);
        queue_request(jps_pkg::MODE_JUMP, 4, 0, 0, 1, 0);
        queue_request(jps_pkg::MODE_JUMP, 5, 5, -1, -1, 0);
        queue_request(jps_pkg::MODE_JUMP, 5, 5, 2'b10, 2'b10, 0);
        queue_request(jps_pkg::MODE_JUMP, 4, 4, 0, 0, 0);
        queue_request(jps_pkg::MODE_JUMP, 3, 3, 0, 0, 0);
        queue_request(jps_pkg::MODE_JUMP, 2, 2, 1, 0, 0);
        queue_request(jps_pkg::MODE_NBR, 1, 1, 1, 1, 0);
        queue_request(jps_pkg::MODE_NBR, 2, 3, 0, -1, 0);
        queue_request(jps_pkg::MODE_NBR, 1, 2, 1, 0, 0);
        queue_request(jps_pkg::MODE_NBR, 0, 0, -1, -1, 0);
        queue_request(jps_pkg::MODE_NBR, 5, 0, 1, 0, 0);
        queue_request(jps_pkg::MODE_NBR, 1, 1, 0, 0, 0);
        queue_request(jps_pkg::MODE_SKIP, 1, 1, 1, 1, 1);
        queue_request(jps_pkg::MODE_JUMP, 63, 63, 1, 1, 0);
        drain();

        // zero-size grid blocks everything; oversize saturates
        apb_write(jps_pkg::REG_GRID_W, 0);
        apb_write(jps_pkg::REG_GRID_H, 127);
        queue_request(jps_pkg::MODE_JUMP, 0, 0, 0, 1, 0);
        queue_request(jps_pkg::MODE_NBR, 0, 0, 1, 1, 0);
        drain();

        // random phases over several settings, each region written before use
        for (int ph = 0; ph < 4; ph++) begin
            int rw, rh;
            case (ph)
                0: begin rw = 1; rh = 1; end
                default: begin rw = $urandom_range(2, 4); rh = $urandom_range(2, 4); end
            endcase
            apb_write(jps_pkg::REG_GRID_W, rw);
            apb_write(jps_pkg::REG_GRID_H, rh);
            apb_write(jps_pkg::REG_GOAL_X, $urandom_range(0, rw-1));
            apb_write(jps_pkg::REG_GOAL_Y, $urandom_range(0, rh-1));
            fill_map(rw, rh, $urandom_range(10, 40));
            for (int i = 0; i < 10; i++) begin
                if ($urandom_range(0, 4) == 0)
                    queue_request(jps_pkg::MODE_WRITE, $urandom_range(0, 63),
                                  $urandom_range(0, 63), 2'($urandom), 2'($urandom),
                                  1'($urandom));
                else
                    random_query(rw, rh);
            end
            drain();
        end

        if (errors == 0 && expected_pts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* files.f */
rtl/jps_pkg.sv
rtl/jps_in_if.sv
rtl/jps_out_if.sv
rtl/jps_datapath.sv
rtl/jps_ctrl.sv
rtl/jump_point_search_step.sv
verif/tb_jump_point_search_step.sv
